// ===== sv/htb_pkg.sv =====
// ----------------------------------------------------------------------------
// htb_pkg: shared types and helpers for the hex text to bytes parser
// Character classification and the record that moves from the front part
// to the back part through the item queue.
// ----------------------------------------------------------------------------
package htb_pkg;

   localparam int BYTES_PER_LINE_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT    = 2;

   // One character as a hex digit: flag and value.
   typedef struct packed {
      logic       is_hex;
      logic [3:0] nib;
   } digit_type;

   // A classified character as the back part sees it.
   typedef struct packed {
      digit_type digit;
      logic      is_blank;
      logic      is_newline;
      logic      last;
   } char_class_type;

   // Head of the item queue toward the back part.
   typedef struct packed {
      logic           valid;
      char_class_type item;
   } queue_head_type;

   function automatic char_class_type classify(input logic [7:0] c, input logic last);
      char_class_type r;
      r.digit.is_hex = 1'b0;
      r.digit.nib    = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         r.digit.is_hex = 1'b1;
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r.digit.is_hex = 1'b1;
         r.digit.nib    = 4'(c[3:0] + 4'd9);
      end
      r.is_blank   = (c == 8'h20) || (c == 8'h09);
      r.is_newline = (c == 8'h0d) || (c == 8'h0a);
      r.last       = last;
      return r;
   endfunction

endpackage

// ===== sv/htb_front.sv =====
// ----------------------------------------------------------------------------
// htb_front: character intake and item queue
// Classifies each transferred character and holds it in a short queue
// until the back part takes it.
// ----------------------------------------------------------------------------
module htb_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [7:0]              req_text_char,
   input  logic                    req_end_of_text,
   output htb_pkg::queue_head_type head,
   input  logic                    head_pop
);
   import htb_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

   char_class_type q_mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign req_full   = (cnt_ff == FULL_CNT) || reset;
   assign do_push    = req_push && !req_full;
   assign do_pop     = head_pop && (cnt_ff != '0);
   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         cnt_in = CW'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= classify(req_text_char, req_end_of_text);
      end
   end

endmodule

// ===== sv/htb_back.sv =====
// ----------------------------------------------------------------------------
// htb_back: line parser and result buffer
// Runs the pair scanner or hex-dump line parser on one classified character
// per cycle when the result buffer has room, and buffers the decoded bytes.
// ----------------------------------------------------------------------------
module htb_back #(
   parameter int BYTES_PER_LINE = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  htb_pkg::queue_head_type head,
   output logic                    head_pop,
   input  logic                    csr_write,
   input  logic                    csr_dump_mode,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [7:0]              rsp_out_byte
);
   import htb_pkg::*;

   localparam logic [2:0] PH_LEAD       = 3'd0;
   localparam logic [2:0] PH_TOKEN      = 3'd1;
   localparam logic [2:0] PH_OFFSET_GAP = 3'd2;
   localparam logic [2:0] PH_DATA_SCAN  = 3'd3;
   localparam logic [2:0] PH_DATA_PAIR  = 3'd4;
   localparam logic [2:0] PH_EOL_TEXT   = 3'd5;
   localparam logic [2:0] PH_EOL_BREAK  = 3'd6;

   localparam logic [4:0] LINE_BYTES = 5'(BYTES_PER_LINE);
   localparam logic [2:0] BLANK_SAT  = 3'd4;
   localparam logic [2:0] GAP_RUN    = 3'd2;

   logic       mode_ff;
   logic [2:0] phase_ff, phase_in;
   digit_type  first_ff, first_in;
   digit_type  second_ff, second_in;
   logic [1:0] held_ff, held_in;
   logic [2:0] blank_ff, blank_in;
   logic       gap_ff, gap_in;
   logic [4:0] lbc_ff, lbc_in;
   logic       emit;
   logic [7:0] emit_byte;

   logic [7:0] out_mem_ff [2];
   logic       out_wr_ff, out_rd_ff;
   logic [1:0] out_cnt_ff, out_cnt_in;
   logic       out_push, out_pop, step;

   char_class_type ch;
   assign ch = head.item;

   // Step when a character waits and the result buffer can take a byte.
   assign step     = head.valid && ((out_cnt_ff != 2'd2) || rsp_pop);
   assign head_pop = step;

   always_comb begin
      logic done;
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      held_in   = held_ff;
      blank_in  = blank_ff;
      gap_in    = gap_ff;
      lbc_in    = lbc_ff;
      emit      = 1'b0;
      emit_byte = '0;
      done      = 1'b0;
      if (mode_ff) begin
         // At most two phases are visited per character.
         for (int i = 0; i < 3; i++) begin
            if (!done) begin
               unique case (phase_in)
                  PH_LEAD: begin
                     done = 1'b1;
                     if (!ch.is_blank) begin
                        first_in = ch.digit;
                        held_in  = 2'd1;
                        phase_in = PH_TOKEN;
                     end
                  end
                  PH_TOKEN: begin
                     if (!ch.is_blank) begin
                        done = 1'b1;
                        if (held_in == 2'd1) begin
                           second_in = ch.digit;
                           held_in   = 2'd2;
                        end else begin
                           held_in = 2'd3;
                        end
                     end else if (held_in == 2'd2) begin
                        gap_in = 1'b0;
                        lbc_in = '0;
                        if (first_in.is_hex && second_in.is_hex) begin
                           emit      = 1'b1;
                           emit_byte = {first_in.nib, second_in.nib};
                           lbc_in    = 5'd1;
                        end
                        held_in  = '0;
                        blank_in = '0;
                        phase_in = (lbc_in == LINE_BYTES) ? PH_EOL_TEXT : PH_DATA_SCAN;
                     end else begin
                        done     = 1'b1;
                        held_in  = '0;
                        blank_in = 3'd1;
                        phase_in = PH_OFFSET_GAP;
                     end
                  end
                  PH_OFFSET_GAP: begin
                     done = 1'b1;
                     if (ch.is_blank) begin
                        if (blank_in < BLANK_SAT) blank_in = 3'(blank_in + 1'b1);
                     end else begin
                        gap_in   = (blank_in >= BLANK_SAT);
                        lbc_in   = '0;
                        blank_in = '0;
                        if (ch.digit.is_hex) begin
                           first_in = ch.digit;
                           held_in  = 2'd1;
                           phase_in = PH_DATA_PAIR;
                        end else begin
                           held_in  = '0;
                           phase_in = PH_DATA_SCAN;
                        end
                     end
                  end
                  PH_DATA_SCAN: begin
                     if (ch.is_blank) begin
                        done = 1'b1;
                        if (blank_in < BLANK_SAT) blank_in = 3'(blank_in + 1'b1);
                     end else if (blank_in >= BLANK_SAT) begin
                        blank_in = '0;
                        phase_in = PH_EOL_TEXT;
                     end else if (gap_in && blank_in >= GAP_RUN) begin
                        blank_in = '0;
                        phase_in = PH_LEAD;
                     end else begin
                        done     = 1'b1;
                        blank_in = '0;
                        if (ch.digit.is_hex) begin
                           first_in = ch.digit;
                           held_in  = 2'd1;
                           phase_in = PH_DATA_PAIR;
                        end else begin
                           held_in  = '0;
                           phase_in = PH_DATA_SCAN;
                        end
                     end
                  end
                  PH_DATA_PAIR: begin
                     held_in  = '0;
                     blank_in = '0;
                     if (ch.digit.is_hex) begin
                        done      = 1'b1;
                        emit      = 1'b1;
                        emit_byte = {first_in.nib, ch.digit.nib};
                        lbc_in    = 5'(lbc_in + 1'b1);
                        phase_in  = (lbc_in == LINE_BYTES) ? PH_EOL_TEXT : PH_DATA_SCAN;
                     end else begin
                        phase_in = PH_DATA_SCAN;
                     end
                  end
                  PH_EOL_TEXT: begin
                     done = 1'b1;
                     if (ch.is_newline) phase_in = PH_EOL_BREAK;
                  end
                  PH_EOL_BREAK: begin
                     if (ch.is_newline) begin
                        done = 1'b1;
                     end else begin
                        phase_in = PH_LEAD;
                     end
                  end
                  default: begin
                     phase_in = PH_LEAD;
                  end
               endcase
            end
         end
         // Flush a two-character token still open at the final character.
         if (ch.last && !emit && phase_in == PH_TOKEN && held_in == 2'd2 &&
             first_in.is_hex && second_in.is_hex) begin
            emit      = 1'b1;
            emit_byte = {first_in.nib, second_in.nib};
         end
      end else if (held_ff != '0) begin
         if (ch.digit.is_hex) begin
            emit      = 1'b1;
            emit_byte = {first_ff.nib, ch.digit.nib};
         end
         held_in = '0;
      end else if (ch.digit.is_hex) begin
         first_in = ch.digit;
         held_in  = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write || (step && ch.last)) begin
         phase_ff  <= PH_LEAD;
         first_ff  <= '0;
         second_ff <= '0;
         held_ff   <= '0;
         blank_ff  <= '0;
         gap_ff    <= 1'b0;
         lbc_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         held_ff   <= held_in;
         blank_ff  <= blank_in;
         gap_ff    <= gap_in;
         lbc_ff    <= lbc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write) begin
         mode_ff <= csr_dump_mode;
      end
   end

   // Two-entry result buffer.
   assign out_push     = step && emit;
   assign out_pop      = rsp_pop && !rsp_empty;
   assign rsp_empty    = (out_cnt_ff == 2'd0) || reset;
   assign rsp_out_byte = out_mem_ff[out_rd_ff];

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = 2'(out_cnt_ff + 1'b1);
      end else if (out_pop && !out_push) begin
         out_cnt_in = 2'(out_cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= '0;
      end else begin
         if (out_push) out_wr_ff <= !out_wr_ff;
         if (out_pop) out_rd_ff <= !out_rd_ff;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= emit_byte;
      end
   end

endmodule

// ===== sv/hex_text_to_bytes_parser_top.sv =====
// ----------------------------------------------------------------------------
// hex_text_to_bytes_parser_top: hex text to byte stream converter
// Plain pair or hex-dump line parsing, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the result side drains, set by
//   the single-step line parser. A character goes through the item queue,
//   then the parser step writes its byte into the result buffer.
// Reset: synchronous; clears both queues, the parse state and dump_mode.
//   A csr write also returns the parse state to line start.
module hex_text_to_bytes_parser_top #(
   parameter int BYTES_PER_LINE = htb_pkg::BYTES_PER_LINE_DEFAULT,
   parameter int QUEUE_DEPTH    = htb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // character input
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_text_char,
   input  logic       req_end_of_text,
   // decoded bytes
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   // mode register
   input  logic       csr_write,
   input  logic       csr_dump_mode
);
   import htb_pkg::*;

   // Classified characters waiting for the parser; the parser pops one per
   // transfer it can pass on.
   queue_head_type head;
   logic           head_pop;

   // Front part: classify and queue each transferred character.
   htb_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_char   (req_text_char),
      .req_end_of_text (req_end_of_text),
      .head            (head),
      .head_pop        (head_pop)
   );

   // Back part: advance the parser and hold decoded bytes until popped.
   htb_back #(
      .BYTES_PER_LINE (BYTES_PER_LINE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_pop      (head_pop),
      .csr_write     (csr_write),
      .csr_dump_mode (csr_dump_mode),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte)
   );

endmodule

// ===== sv/htb_checker.sv =====
// ----------------------------------------------------------------------------
// htb_checker: port-level checks for the hex text to bytes parser
// Watches the queue-style ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module htb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte
);

   // Come out of reset with nothing held and room for input.
   a_reset_clean: assert property (@(posedge clock)
      reset ##1 !reset |-> rsp_empty && !req_full)
      else $error("not empty or full right after reset");

   // A waiting result holds until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_out_byte))
      else $error("result changed while waiting");

   // The input side backs up only behind undrained results.
   a_full_needs_results: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input full while no result waits");

   // With the result side draining, a full input side clears next cycle.
   a_full_drains: assert property (@(posedge clock) disable iff (reset)
      (req_full && rsp_pop) |=> !req_full)
      else $error("input stayed full while results were drained");

endmodule

bind hex_text_to_bytes_parser_top htb_checker u_htb_checker (.*);
